@@ rtl/core/jdi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdi_pkg
// Shared types, constants and tables for the joystick direction indicator.
// ----------------------------------------------------------------------------
package jdi_pkg;

  localparam int LED_COUNT    = 8;
  localparam int LED_W        = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int SQRT_STEPS   = 18;
  localparam int DIV_STEPS    = 24;
  localparam int ITER_W       = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Angle units: fine accumulator is 2^-16 degree, output is 1/64 degree.
  localparam int ACC_W        = 27;
  localparam int DEG180_FINE  = 11796480;
  localparam int DEG360_FINE  = 23592960;
  localparam int ANG_ROUND    = 512;
  localparam int ANG_FULL     = 23040;
  localparam int ANG_Q1       = 5760;
  localparam int ANG_Q2       = 11520;
  localparam int ANG_Q3       = 17280;

  // LED index: angle * LED_COUNT / LED_DIV through a reciprocal with one fixup.
  localparam int LED_DIV      = 11520;
  localparam int LED_RECIP_SH = 32;
  localparam int RECIP_W      = 20;
  localparam logic [RECIP_W-1:0] LED_RECIP =
    RECIP_W'(((64'd1 << LED_RECIP_SH) + 64'(LED_DIV) - 64'd1) / 64'(LED_DIV));
  localparam int T_W  = 15 + LED_W + 1;
  localparam int QE_W = $clog2(2 * LED_COUNT + 2);

  localparam int DIST_MAX   = 131071;
  localparam int INTEN_ONE  = 4096;
  localparam int BLINK_BIAS = 45056;
  localparam int BLINK_SH   = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_FULL_SCALE = 3'd2,
    REG_DEAD_X     = 3'd3,
    REG_DEAD_Y     = 3'd4,
    REG_UPDATE_INT = 3'd5,
    REG_BLINK_BASE = 3'd6
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_OFFSET, ST_MULX, ST_MULY, ST_CORDIC, ST_ANGFIX,
    ST_MULQX, ST_MULQY, ST_SQRTD, ST_DIVQ, ST_SQINIT, ST_SQRTQ, ST_COMMIT,
    ST_LEDEST, ST_LEDSET, ST_BLINKPREP, ST_BLINKTEST, ST_EMIT
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_SAMPLE, OP_TICK, OP_OFFSET, OP_MULX, OP_MULY, OP_CORDIC,
    OP_ANGFIX, OP_MULQX, OP_MULQY, OP_SQRTD, OP_DIVQ, OP_SQINIT, OP_SQRTQ,
    OP_COMMIT, OP_LEDEST, OP_LEDSET, OP_BLINKPREP, OP_BLINKTEST, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [ITER_W-1:0] iter;
  } dp_cmd_t;

  typedef struct packed {
    logic data_ready;
    logic update_due;
    logic ox_zero;
    logic out_free;
  } dp_stat_t;

  function automatic logic [21:0] atan_fine(input logic [ITER_W-1:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/jdi_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdi_ctrl
// Sequencer: input handshake, step ordering and iteration counts.
// ----------------------------------------------------------------------------
module jdi_ctrl import jdi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_req_type,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [ITER_W-1:0] CORDIC_LAST = ITER_W'(CORDIC_STEPS - 1);
  localparam logic [ITER_W-1:0] SQRT_LAST   = ITER_W'(SQRT_STEPS - 1);
  localparam logic [ITER_W-1:0] DIV_LAST    = ITER_W'(DIV_STEPS - 1);

  ctrl_state_t       state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = in_req_type ? ST_CHECK : ST_EMIT;
      end
      ST_CHECK: begin
        if (!stat.data_ready)     state_nxt = ST_EMIT;
        else if (stat.update_due) state_nxt = ST_OFFSET;
        else                      state_nxt = ST_BLINKPREP;
      end
      ST_OFFSET:  state_nxt = ST_MULX;
      ST_MULX:    state_nxt = stat.ox_zero ? ST_BLINKPREP : ST_MULY;
      ST_MULY:    state_nxt = ST_CORDIC;
      ST_CORDIC: begin
        if (iter_r == CORDIC_LAST) state_nxt = ST_ANGFIX;
      end
      ST_ANGFIX:  state_nxt = ST_MULQX;
      ST_MULQX:   state_nxt = ST_MULQY;
      ST_MULQY:   state_nxt = ST_SQRTD;
      ST_SQRTD: begin
        if (iter_r == SQRT_LAST) state_nxt = ST_DIVQ;
      end
      ST_DIVQ: begin
        if (iter_r == DIV_LAST) state_nxt = ST_SQINIT;
      end
      ST_SQINIT:  state_nxt = ST_SQRTQ;
      ST_SQRTQ: begin
        if (iter_r == SQRT_LAST) state_nxt = ST_COMMIT;
      end
      ST_COMMIT:    state_nxt = ST_LEDEST;
      ST_LEDEST:    state_nxt = ST_LEDSET;
      ST_LEDSET:    state_nxt = ST_BLINKPREP;
      ST_BLINKPREP: state_nxt = ST_BLINKTEST;
      ST_BLINKTEST: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign iter_nxt = (state_nxt != state_r) ? '0 : iter_r + 1'b1;

  always_comb begin
    cmd.iter = iter_r;
    case (state_r)
      ST_IDLE:      cmd.op = accept ? (in_req_type ? OP_TICK : OP_SAMPLE) : OP_NOP;
      ST_CHECK:     cmd.op = OP_NOP;
      ST_OFFSET:    cmd.op = OP_OFFSET;
      ST_MULX:      cmd.op = OP_MULX;
      ST_MULY:      cmd.op = OP_MULY;
      ST_CORDIC:    cmd.op = OP_CORDIC;
      ST_ANGFIX:    cmd.op = OP_ANGFIX;
      ST_MULQX:     cmd.op = OP_MULQX;
      ST_MULQY:     cmd.op = OP_MULQY;
      ST_SQRTD:     cmd.op = OP_SQRTD;
      ST_DIVQ:      cmd.op = OP_DIVQ;
      ST_SQINIT:    cmd.op = OP_SQINIT;
      ST_SQRTQ:     cmd.op = OP_SQRTQ;
      ST_COMMIT:    cmd.op = OP_COMMIT;
      ST_LEDEST:    cmd.op = OP_LEDEST;
      ST_LEDSET:    cmd.op = OP_LEDSET;
      ST_BLINKPREP: cmd.op = OP_BLINKPREP;
      ST_BLINKTEST: cmd.op = OP_BLINKTEST;
      ST_EMIT:      cmd.op = stat.out_free ? OP_EMIT : OP_NOP;
      default:      cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

endmodule

@@ rtl/core/jdi_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdi_dp
// Datapath: config, time keeping, CORDIC, shared square root, divider,
// LED selection, blink timer and the output word register.
// ----------------------------------------------------------------------------
module jdi_dp import jdi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  logic [11:0]           in_x_sample,
  input  logic [11:0]           in_y_sample,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_led_pattern,
  output logic [2:0]            out_led_index,
  output logic [14:0]           out_angle_out,
  output logic [16:0]           out_distance_out,
  output logic [12:0]           out_intensity_out,
  output logic signed [13:0]    out_offset_x,
  output logic signed [13:0]    out_offset_y
);

  localparam int CW   = 34;
  localparam int SQ_W = 36;

  function automatic logic [13:0] mag15(input logic signed [14:0] v);
    return v[14] ? 14'(-v) : 14'(v);
  endfunction

  // configuration
  logic [11:0] cx_r, cy_r, base_r;
  logic [12:0] fs_r;
  logic [5:0]  dx_r, dy_r;
  logic [9:0]  upd_int_r;

  // architectural state
  logic [31:0]          now_r, last_upd_r, last_blink_r;
  logic [12:0]          held_x_r;
  logic [11:0]          held_y_r;
  logic                 ready_r;
  logic [14:0]          angle_r;
  logic [16:0]          dist_r;
  logic [12:0]          inten_r;
  logic signed [13:0]   offx_r, offy_r;
  logic [LED_W-1:0]     sel_r;
  logic                 lit_r;
  logic                 out_valid_r;

  // work registers
  logic signed [14:0]   ox_r;
  logic signed [13:0]   oy_r;
  logic [27:0]          prod_r, d2_r, c2_r;
  logic signed [CW-1:0] cx_w_r, cy_w_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [14:0]          ang_r;
  logic [SQ_W-1:0]      sq_v_r, sq_q_r, sq_b_r;
  logic [27:0]          rem_r;
  logic [DIV_STEPS-1:0] quo_r;
  logic                 quo_sat_r;
  logic [16:0]          dtmp_r;
  logic [QE_W-1:0]      qe_r;
  logic [34:0]          e5_r;
  logic [28:0]          rhs_r;

  // combinational helpers
  logic signed [14:0] ox_c, qx_c, qy_c;
  logic signed [13:0] oy_c;
  logic [27:0]        sq_ox, sq_oy, sq_qx, sq_qy;
  logic [12:0]        held_x_c;
  logic [31:0]        upd_elap, blink_elap;
  logic signed [CW-1:0]    cx_sh, cy_sh;
  logic signed [ACC_W-1:0] atan_c, acc_wrap;
  logic [ACC_W-1:0]        acc_rnd;
  logic [14:0]        ang_c;
  logic [SQ_W-1:0]    sq_trial;
  logic [28:0]        rem2;
  logic [12:0]        lim_c;
  logic [T_W-1:0]     t_c;
  logic [T_W+RECIP_W-1:0] tm_c;
  logic [QE_W+13:0]   qchk_c;
  logic [QE_W-1:0]    q_c, idx_c;
  logic [16:0]        i10_c, diff_c;
  logic [31:0]        pat_c;

  assign held_x_c = (13'(in_x_sample) > fs_r) ? 13'd0 : fs_r - 13'(in_x_sample);
  assign ox_c = $signed({2'b00, held_x_r}) - $signed({3'b000, cx_r});
  assign oy_c = $signed({2'b00, held_y_r}) - $signed({2'b00, cy_r});
  assign upd_elap   = now_r - last_upd_r;
  assign blink_elap = now_r - last_blink_r;

  // quadrant corner, chosen from the unmasked angle
  always_comb begin
    if (ang_r < 15'(ANG_Q1)) begin
      qx_c = $signed({2'b00, fs_r}) - $signed({3'b000, cx_r});
      qy_c = $signed({2'b00, fs_r}) - $signed({3'b000, cy_r});
    end else if (ang_r < 15'(ANG_Q2)) begin
      qx_c = $signed({3'b000, cx_r});
      qy_c = $signed({2'b00, fs_r}) - $signed({3'b000, cy_r});
    end else if (ang_r < 15'(ANG_Q3)) begin
      qx_c = $signed({3'b000, cx_r});
      qy_c = $signed({3'b000, cy_r});
    end else begin
      qx_c = $signed({2'b00, fs_r}) - $signed({3'b000, cx_r});
      qy_c = $signed({3'b000, cy_r});
    end
  end

  assign sq_ox = mag15(ox_r) * mag15(ox_r);
  assign sq_oy = mag15(15'(oy_r)) * mag15(15'(oy_r));
  assign sq_qx = mag15(qx_c) * mag15(qx_c);
  assign sq_qy = mag15(qy_c) * mag15(qy_c);

  // CORDIC micro-rotation
  assign cx_sh  = cx_w_r >>> cmd.iter;
  assign cy_sh  = cy_w_r >>> cmd.iter;
  assign atan_c = $signed(ACC_W'(atan_fine(cmd.iter)));

  always_comb begin
    if (acc_r < 0)                        acc_wrap = acc_r + ACC_W'(DEG360_FINE);
    else if (acc_r >= ACC_W'(DEG360_FINE)) acc_wrap = acc_r - ACC_W'(DEG360_FINE);
    else                                  acc_wrap = acc_r;
    acc_rnd = ACC_W'(acc_wrap + ACC_W'(ANG_ROUND)) >> 10;
    ang_c   = (acc_rnd[14:0] >= 15'(ANG_FULL)) ? acc_rnd[14:0] - 15'(ANG_FULL)
                                               : acc_rnd[14:0];
  end

  assign sq_trial = sq_q_r + sq_b_r;
  assign rem2     = {rem_r, 1'b0};
  assign lim_c    = (13'(dx_r) * 13'(dx_r)) + (13'(dy_r) * 13'(dy_r));

  // LED selection
  assign t_c    = T_W'(angle_r) * T_W'(LED_COUNT);
  assign tm_c   = (T_W+RECIP_W)'(t_c) * (T_W+RECIP_W)'(LED_RECIP);
  assign qchk_c = (QE_W+14)'(qe_r) * (QE_W+14)'(LED_DIV);
  always_comb begin
    q_c   = (qchk_c > (QE_W+14)'(t_c)) ? qe_r - 1'b1 : qe_r;
    idx_c = QE_W'(q_c + 1'b1) >> 1;
    if (idx_c >= QE_W'(LED_COUNT)) idx_c = idx_c - QE_W'(LED_COUNT);
  end

  assign i10_c  = {1'b0, inten_r, 3'b000} + {3'b000, inten_r, 1'b0};
  assign diff_c = (i10_c <= 17'(BLINK_BIAS)) ? 17'(BLINK_BIAS) - i10_c
                                             : i10_c - 17'(BLINK_BIAS);
  assign pat_c  = lit_r ? (32'd1 << sel_r) : 32'd0;

  assign stat.data_ready = ready_r;
  assign stat.update_due = upd_elap > 32'(upd_int_r);
  assign stat.ox_zero    = (ox_r == '0);
  assign stat.out_free   = !out_valid_r || !out_stall;

  // architectural and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= 12'd537; cy_r <= 12'd497; fs_r <= 13'd4096;
      dx_r <= 6'd5; dy_r <= 6'd5; upd_int_r <= 10'd10; base_r <= 12'd250;
      now_r <= '0; last_upd_r <= '0; last_blink_r <= '0;
      held_x_r <= '0; held_y_r <= '0; ready_r <= 1'b0;
      angle_r <= '0; dist_r <= '0; inten_r <= '0;
      offx_r <= '0; offy_r <= '0; sel_r <= '0; lit_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_CENTER_X:   cx_r      <= cfg_wdata[11:0];
          REG_CENTER_Y:   cy_r      <= cfg_wdata[11:0];
          REG_FULL_SCALE: fs_r      <= cfg_wdata;
          REG_DEAD_X:     dx_r      <= cfg_wdata[5:0];
          REG_DEAD_Y:     dy_r      <= cfg_wdata[5:0];
          REG_UPDATE_INT: upd_int_r <= cfg_wdata[9:0];
          REG_BLINK_BASE: base_r    <= cfg_wdata[11:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_EMIT) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_SAMPLE: begin
          held_x_r <= held_x_c;
          held_y_r <= in_y_sample;
          ready_r  <= 1'b1;
        end
        OP_TICK: now_r <= now_r + 32'd1;
        OP_OFFSET: begin
          last_upd_r <= now_r;
          offx_r     <= 14'(ox_c);
          offy_r     <= oy_c;
        end
        OP_COMMIT: begin
          angle_r <= ({1'b0, dtmp_r} < {1'b0, lim_c, 4'b0000}) ? 15'd0 : ang_r;
          dist_r  <= dtmp_r;
          inten_r <= sq_q_r[12:0];
        end
        OP_LEDSET: begin
          sel_r <= LED_W'(idx_c);
          if (LED_W'(idx_c) != sel_r) lit_r <= 1'b1;
        end
        OP_BLINKTEST: begin
          if ({e5_r, {BLINK_SH{1'b0}}} > (35 + BLINK_SH)'(rhs_r)) begin
            last_blink_r <= now_r;
            lit_r        <= !lit_r;
          end
        end
        default: ;
      endcase
    end
  end

  // work registers and output word
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_OFFSET: begin
        ox_r <= ox_c;
        oy_r <= oy_c;
      end
      OP_MULX: begin
        prod_r <= sq_ox;
        if (ox_r[14]) begin
          cx_w_r <= -(CW'(ox_r) <<< 16);
          cy_w_r <= -(CW'(oy_r) <<< 16);
          acc_r  <= ACC_W'(DEG180_FINE);
        end else begin
          cx_w_r <= CW'(ox_r) <<< 16;
          cy_w_r <= CW'(oy_r) <<< 16;
          acc_r  <= '0;
        end
      end
      OP_MULY: d2_r <= prod_r + sq_oy;
      OP_CORDIC: begin
        if (!cy_w_r[CW-1]) begin
          cx_w_r <= cx_w_r + cy_sh;
          cy_w_r <= cy_w_r - cx_sh;
          acc_r  <= acc_r + atan_c;
        end else begin
          cx_w_r <= cx_w_r - cy_sh;
          cy_w_r <= cy_w_r + cx_sh;
          acc_r  <= acc_r - atan_c;
        end
      end
      OP_ANGFIX: ang_r <= ang_c;
      OP_MULQX:  prod_r <= sq_qx;
      OP_MULQY: begin
        c2_r   <= prod_r + sq_qy;
        sq_v_r <= SQ_W'({d2_r, 8'h00});
        sq_q_r <= '0;
        sq_b_r <= SQ_W'(1) << (SQ_W - 2);
      end
      OP_SQRTD, OP_SQRTQ: begin
        if (sq_v_r >= sq_trial) begin
          sq_v_r <= sq_v_r - sq_trial;
          sq_q_r <= (sq_q_r >> 1) + sq_b_r;
        end else begin
          sq_q_r <= sq_q_r >> 1;
        end
        sq_b_r <= sq_b_r >> 2;
        // load the divider while the first root runs
        if (cmd.op == OP_SQRTD && cmd.iter == '0) begin
          rem_r     <= d2_r;
          quo_r     <= '0;
          quo_sat_r <= (d2_r >= c2_r);
        end
      end
      OP_DIVQ: begin
        if (rem2 >= {1'b0, c2_r}) begin
          rem_r <= 28'(rem2 - {1'b0, c2_r});
          quo_r <= {quo_r[DIV_STEPS-2:0], 1'b1};
        end else begin
          rem_r <= rem2[27:0];
          quo_r <= {quo_r[DIV_STEPS-2:0], 1'b0};
        end
      end
      OP_SQINIT: begin
        dtmp_r <= (sq_q_r > SQ_W'(DIST_MAX)) ? 17'(DIST_MAX) : sq_q_r[16:0];
        sq_v_r <= quo_sat_r ? SQ_W'(INTEN_ONE * INTEN_ONE) : SQ_W'(quo_r);
        sq_q_r <= '0;
        sq_b_r <= SQ_W'(1) << (SQ_W - 2);
      end
      OP_LEDEST: qe_r <= QE_W'(tm_c >> LED_RECIP_SH);
      OP_BLINKPREP: begin
        e5_r  <= {1'b0, blink_elap, 2'b00} + 35'(blink_elap);
        rhs_r <= 29'(base_r) * 29'(diff_c);
      end
      OP_EMIT: begin
        out_led_pattern   <= pat_c[7:0];
        out_led_index     <= 3'(sel_r);
        out_angle_out     <= angle_r;
        out_distance_out  <= dist_r;
        out_intensity_out <= inten_r;
        out_offset_x      <= offx_r;
        out_offset_y      <= offy_r;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/joystick_direction_indicator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_direction_indicator
// Joystick sample and tick processor that drives a ring of direction LEDs.
// ----------------------------------------------------------------------------
// Input words carry either a sample pair (in_req_type 0) or a one millisecond
// tick (in_req_type 1). Every accepted word gives exactly one output word that
// shows the LED pattern, LED index, angle, distance, intensity and offsets
// after that word took effect.
// A sample word goes from accept straight to the emit state; a tick with no
// recompute skips the arithmetic steps; a tick that recomputes runs the CORDIC
// loop, the shared bit-serial square root (18 steps, used twice) and the
// 24-step restoring divider, all in turn under the sequencer. One word is in
// flight at a time.
// The output word sits in a register: the next input word is taken while it
// waits. With out_stall high the word and out_valid hold, and the block
// holds in_stall high once it has its next result ready.
// Reset (rst_n low, synchronous) loads the register defaults, clears time,
// held samples and results, and turns all LEDs off. Config writes go on the
// cfg port at any time the block is idle.
// ----------------------------------------------------------------------------
module joystick_direction_indicator import jdi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [11:0]           in_x_sample,
  input  logic [11:0]           in_y_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_led_pattern,
  output logic [2:0]            out_led_index,
  output logic [14:0]           out_angle_out,
  output logic [16:0]           out_distance_out,
  output logic [12:0]           out_intensity_out,
  output logic signed [13:0]    out_offset_x,
  output logic signed [13:0]    out_offset_y,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: owns the input handshake and steps the datapath
  jdi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  // datapath: state, arithmetic units and the output word register
  jdi_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_x_sample       (in_x_sample),
    .in_y_sample       (in_y_sample),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_led_pattern   (out_led_pattern),
    .out_led_index     (out_led_index),
    .out_angle_out     (out_angle_out),
    .out_distance_out  (out_distance_out),
    .out_intensity_out (out_intensity_out),
    .out_offset_x      (out_offset_x),
    .out_offset_y      (out_offset_y)
  );

endmodule

@@ rtl/core/jdi_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdi_checker
// Port-level checks for the joystick direction indicator.
// ----------------------------------------------------------------------------
module jdi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_led_pattern,
  input logic [2:0]  out_led_index,
  input logic [14:0] out_angle_out,
  input logic [12:0] out_intensity_out
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_led_pattern))
    else $error("output word dropped or changed under stall");

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_led_pattern))
    else $error("more than one LED lit");

  a_led_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_led_pattern != 8'd0 |-> out_led_pattern == (8'd1 << out_led_index))
    else $error("lit LED differs from LED index");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angle_out < 15'd23040 && out_intensity_out <= 13'd4096)
    else $error("angle or intensity out of range");

endmodule

bind joystick_direction_indicator jdi_checker u_jdi_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_led_pattern   (out_led_pattern),
  .out_led_index     (out_led_index),
  .out_angle_out     (out_angle_out),
  .out_intensity_out (out_intensity_out)
);
